FILE: src/bmmu_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bmmu_pkg
// Shared types and constants for the banked memory MMU bus decoder.
// ----------------------------------------------------------------------------
package bmmu_pkg;

    // Target region codes reported with every decoded request.
    localparam logic [2:0] TGT_RAM  = 3'd0;
    localparam logic [2:0] TGT_IO   = 3'd1;
    localparam logic [2:0] TGT_BLO  = 3'd2;
    localparam logic [2:0] TGT_BHI  = 3'd3;
    localparam logic [2:0] TGT_CHR  = 3'd4;
    localparam logic [2:0] TGT_KRN  = 3'd5;
    localparam logic [2:0] TGT_MMU  = 3'd6;
    localparam logic [2:0] TGT_OPEN = 3'd7;

    // MMU register numbers in the D500 window; the FF00 shadow uses numbers 0 to 4.
    localparam logic [3:0] REG_CR      = 4'd0;
    localparam logic [3:0] REG_PCR_A   = 4'd1;
    localparam logic [3:0] REG_PCR_B   = 4'd2;
    localparam logic [3:0] REG_PCR_C   = 4'd3;
    localparam logic [3:0] REG_PCR_D   = 4'd4;
    localparam logic [3:0] REG_MODE    = 4'd5;
    localparam logic [3:0] REG_RCR     = 4'd6;
    localparam logic [3:0] REG_P0L     = 4'd7;
    localparam logic [3:0] REG_P0H     = 4'd8;
    localparam logic [3:0] REG_P1L     = 4'd9;
    localparam logic [3:0] REG_P1H     = 4'd10;
    localparam logic [3:0] REG_VERSION = 4'd11;

    // Access kinds.
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Fixed read values and bit positions.
    localparam logic [7:0] MODE_READ_VALUE    = 8'hB9;
    localparam logic [7:0] VERSION_READ_VALUE = 8'h20;
    localparam logic [7:0] OPEN_BUS_VALUE     = 8'hFF;
    localparam int         MODE_C64_BIT       = 6;
    localparam int         CR_BANK_BIT        = 6;

    // Common RAM sizes selected by rcr bits 1:0.
    localparam logic [16:0] COMMON_1K  = 17'd1024;
    localparam logic [16:0] COMMON_4K  = 17'd4096;
    localparam logic [16:0] COMMON_8K  = 17'd8192;
    localparam logic [16:0] COMMON_16K = 17'd16384;
    localparam logic [16:0] BANK_SIZE  = 17'h10000;

    // One CPU bus request.
    typedef struct packed {
        logic        op;
        logic [15:0] cpu_addr;
        logic [7:0]  write_data;
    } req_t;

    // One decoded result.
    typedef struct packed {
        logic [2:0]  target;
        logic [16:0] phys_offset;
        logic [7:0]  read_data;
        logic        c64_mode_request;
    } res_t;

    // MMU register file. Page high registers keep bit 0 only.
    typedef struct packed {
        logic [7:0]      cr;
        logic [3:0][7:0] pcr;
        logic [7:0]      rcr;
        logic [7:0]      p0l;
        logic            p0h;
        logic [7:0]      p1l;
        logic            p1h;
    } mmu_state_t;

    localparam mmu_state_t STATE_RESET = '{
        cr:  8'h00,
        pcr: '0,
        rcr: 8'h00,
        p0l: 8'h00,
        p0h: 1'b0,
        p1l: 8'h01,
        p1h: 1'b0
    };

endpackage : bmmu_pkg
`default_nettype wire

FILE: src/bmmu_decode.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bmmu_decode
// Decodes one bus request against the current MMU registers and produces the
// result and the register values that follow the request.
// ----------------------------------------------------------------------------
module bmmu_decode (
    input  wire bmmu_pkg::req_t     req,
    input  wire bmmu_pkg::mmu_state_t st_cur,
    output bmmu_pkg::res_t           res,
    output bmmu_pkg::mmu_state_t     st_next
);

    // Register read mux for the MMU window and the shadow locations.
    function automatic logic [7:0] mmu_read(input logic [3:0] idx,
                                            input bmmu_pkg::mmu_state_t st);
        logic [7:0] v;
        unique case (idx) inside
            bmmu_pkg::REG_CR: v = st.cr;
            bmmu_pkg::REG_PCR_A, bmmu_pkg::REG_PCR_B,
            bmmu_pkg::REG_PCR_C, bmmu_pkg::REG_PCR_D: v = st.pcr[idx[1:0] - 2'd1];
            bmmu_pkg::REG_MODE: v = bmmu_pkg::MODE_READ_VALUE;
            bmmu_pkg::REG_RCR:  v = st.rcr;
            bmmu_pkg::REG_P0L:  v = st.p0l;
            bmmu_pkg::REG_P0H:  v = {7'd0, st.p0h};
            bmmu_pkg::REG_P1L:  v = st.p1l;
            bmmu_pkg::REG_P1H:  v = {7'd0, st.p1h};
            default:            v = bmmu_pkg::VERSION_READ_VALUE;
        endcase
        return v;
    endfunction

    // Logical to physical RAM mapping: bank select, page relocation, common RAM.
    function automatic logic [16:0] ram_map(input logic [15:0] a16,
                                            input bmmu_pkg::mmu_state_t st);
        logic [16:0] a;
        logic [16:0] size;
        logic [16:0] low;
        a = {st.cr[bmmu_pkg::CR_BANK_BIT], a16};
        if (a[16:8] == {st.p0h, st.p0l}) begin
            a = {st.p0h, 8'h00, a[7:0]};
        end else if (a[16:8] == {st.p1h, st.p1l}) begin
            a = {st.p1h, 8'h01, a[7:0]};
        end else if (a[15:8] == 8'h00) begin
            a = {st.p0h, st.p0l, a[7:0]};
        end else if (a[15:8] == 8'h01) begin
            a = {st.p1h, st.p1l, a[7:0]};
        end
        case (st.rcr[1:0])
            2'd0:    size = bmmu_pkg::COMMON_1K;
            2'd1:    size = bmmu_pkg::COMMON_4K;
            2'd2:    size = bmmu_pkg::COMMON_8K;
            default: size = bmmu_pkg::COMMON_16K;
        endcase
        low = {1'b0, a[15:0]};
        if (st.rcr[3:2] != 2'b00 && a[16]) begin
            if (st.rcr[2] && low < size) begin
                a = low;
            end else if (st.rcr[3] && (low + size) >= bmmu_pkg::BANK_SIZE) begin
                a = low;
            end
        end
        return a;
    endfunction

    logic [15:0] addr;
    logic        wr;
    logic        is_shadow;
    logic        in_io;
    logic        io_vis;
    logic        is_mmu;
    logic        rom_top;
    logic        rom_hi;
    logic        rom_lo;
    logic [3:0]  shadow_idx;
    logic [3:0]  win_idx;

    assign addr       = req.cpu_addr;
    assign wr         = (req.op == bmmu_pkg::OP_WRITE);
    assign is_shadow  = (addr[15:8] == 8'hFF) && (addr[7:0] <= 8'h04);
    assign in_io      = (addr[15:12] == 4'hD);
    assign io_vis     = in_io && !st_cur.cr[0];
    assign is_mmu     = io_vis && (addr[11:8] == 4'h5) && (addr[7:0] < 8'h0C);
    assign shadow_idx = {1'b0, addr[2:0]};
    assign win_idx    = addr[3:0];
    assign rom_top    = (addr[15:14] == 2'b11) && (st_cur.cr[5:4] != 2'b11);
    assign rom_hi     = (addr[15:14] == 2'b10) && (st_cur.cr[3:2] != 2'b11);
    assign rom_lo     = (addr[15:14] == 2'b01) && !st_cur.cr[1];

    // Region selection, result fields and register updates.
    always_comb begin
        res         = '0;
        res.target  = bmmu_pkg::TGT_OPEN;
        st_next     = st_cur;
        if (is_shadow) begin
            res.target      = bmmu_pkg::TGT_MMU;
            res.phys_offset = {13'd0, shadow_idx};
            if (!wr) begin
                res.read_data = mmu_read(shadow_idx, st_cur);
            end else if (shadow_idx == bmmu_pkg::REG_CR) begin
                st_next.cr = req.write_data;
            end else begin
                st_next.cr = st_cur.pcr[shadow_idx[1:0] - 2'd1];
            end
        end else if (wr) begin
            if (is_mmu) begin
                res.target      = bmmu_pkg::TGT_MMU;
                res.phys_offset = {13'd0, win_idx};
                unique case (win_idx) inside
                    bmmu_pkg::REG_CR: st_next.cr = req.write_data;
                    bmmu_pkg::REG_PCR_A, bmmu_pkg::REG_PCR_B,
                    bmmu_pkg::REG_PCR_C, bmmu_pkg::REG_PCR_D:
                        st_next.pcr[win_idx[1:0] - 2'd1] = req.write_data;
                    bmmu_pkg::REG_MODE:
                        res.c64_mode_request = req.write_data[bmmu_pkg::MODE_C64_BIT];
                    bmmu_pkg::REG_RCR: st_next.rcr = req.write_data;
                    bmmu_pkg::REG_P0L: st_next.p0l = req.write_data;
                    bmmu_pkg::REG_P0H: st_next.p0h = req.write_data[0];
                    bmmu_pkg::REG_P1L: st_next.p1l = req.write_data;
                    bmmu_pkg::REG_P1H: st_next.p1h = req.write_data[0];
                    default: ;
                endcase
            end else if (io_vis) begin
                res.target      = bmmu_pkg::TGT_IO;
                res.phys_offset = {5'd0, addr[11:0]};
            end else begin
                res.target      = bmmu_pkg::TGT_RAM;
                res.phys_offset = ram_map(addr, st_cur);
            end
        end else begin
            if (!rom_top && !rom_hi && !rom_lo && !io_vis) begin
                res.target      = bmmu_pkg::TGT_RAM;
                res.phys_offset = ram_map(addr, st_cur);
            end else if (is_mmu) begin
                res.target      = bmmu_pkg::TGT_MMU;
                res.phys_offset = {13'd0, win_idx};
                res.read_data   = mmu_read(win_idx, st_cur);
            end else if (io_vis) begin
                res.target      = bmmu_pkg::TGT_IO;
                res.phys_offset = {5'd0, addr[11:0]};
            end else if (rom_lo) begin
                res.target      = bmmu_pkg::TGT_BLO;
                res.phys_offset = {3'd0, addr[13:0]};
            end else if (rom_hi && st_cur.cr[3:2] == 2'b00) begin
                res.target      = bmmu_pkg::TGT_BHI;
                res.phys_offset = {3'd0, addr[13:0]};
            end else if (rom_top && st_cur.cr[5:4] == 2'b00 && in_io) begin
                res.target      = bmmu_pkg::TGT_CHR;
                res.phys_offset = {5'd0, addr[11:0]};
            end else if (rom_top && st_cur.cr[5:4] == 2'b00) begin
                res.target      = bmmu_pkg::TGT_KRN;
                res.phys_offset = {3'd0, addr[13:0]};
            end else begin
                // Function ROM area, which is not modeled, reads as open bus.
                res.target    = bmmu_pkg::TGT_OPEN;
                res.read_data = bmmu_pkg::OPEN_BUS_VALUE;
            end
        end
    end

endmodule : bmmu_decode
`default_nettype wire

FILE: src/banked_memory_mmu_decode.sv
`default_nettype none
// A request accepted into the input register moves into the result register,
// which drives m_tvalid. Throughput: one request per cycle unless m_tready
// stalls; the MMU registers update as a request moves into the result
// register, so the next request sees them at once.
// Reset (aresetn low, synchronous) empties both registers and loads the MMU
// registers with their power-on values.
// ----------------------------------------------------------------------------
// banked_memory_mmu_decode
// Stream wrapper around the MMU decoder: holds the register file and the
// input and result registers with their handshakes.
// ----------------------------------------------------------------------------
module banked_memory_mmu_decode (
    input  wire        aclk,
    input  wire        aresetn,
    input  wire        s_tvalid,
    output logic       s_tready,
    input  wire [23:0] s_tdata,   // [15:0] cpu_addr, [23:16] write_data
    input  wire [0:0]  s_tuser,   // [0] op
    output logic       m_tvalid,
    input  wire        m_tready,
    output logic [31:0] m_tdata,  // [16:0] phys_offset, [24:17] read_data,
                                  // [25] c64_mode_request, [31:26] zero
    output logic [2:0] m_tuser    // [2:0] target
);

    logic                 in_vld_reg;
    bmmu_pkg::req_t       req_reg;
    logic                 out_vld_reg;
    bmmu_pkg::res_t       res_reg;
    bmmu_pkg::mmu_state_t st_reg;
    bmmu_pkg::mmu_state_t st_next;
    bmmu_pkg::res_t       res_next;
    logic                 advance;

    // Handshake: the input register moves on whenever the result register
    // is empty or is being drained.
    assign advance  = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || advance;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tready) begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            req_reg.op         <= s_tuser[0];
            req_reg.cpu_addr   <= s_tdata[15:0];
            req_reg.write_data <= s_tdata[23:16];
        end
    end

    bmmu_decode u_decode (
        .req     (req_reg),
        .st_cur  (st_reg),
        .res     (res_next),
        .st_next (st_next)
    );

    // MMU register file, updated as each request is decoded.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= bmmu_pkg::STATE_RESET;
        end else if (advance) begin
            st_reg <= st_next;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (!out_vld_reg || m_tready) begin
            out_vld_reg <= in_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tuser  = res_reg.target;
    assign m_tdata  = {6'd0, res_reg.c64_mode_request, res_reg.read_data,
                       res_reg.phys_offset};

endmodule : banked_memory_mmu_decode
`default_nettype wire
